@@ rtl/optb_pkg.sv @@
// shared types and constants for the output pulse timer bank
package optb_pkg;

    localparam int OPCODE_W   = 3;
    localparam int CHANNEL_W  = 3;
    localparam int DUR_W      = 16;
    localparam int PINS_OUT_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    // wide enough for lane indices 0..31
    localparam int LANE_IDX_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_TOGGLE = 3'd2,
        OP_PULSE  = 3'd3,
        OP_GET    = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_MASK = 1'b0,
        CFG_TICK_ENABLE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [PINS_OUT_W-1:0] pin_levels;
        logic                  read_level;
    } t_result;

endpackage

@@ rtl/output_pulse_timer_bank.sv @@
// top level of the output pulse timer bank
//
// Input channel: i_in_valid / o_in_stall carry one command beat (opcode,
// channel, level, pulse_ticks). A beat is taken at a rising edge with valid
// high and stall low. Output channel: o_out_valid / i_out_stall carry one
// result beat per command: the physical levels of pins 0..7 after the
// command and, for get, the logical level of the addressed pin.
// Every command is applied by per-pin lane logic; all pulse counters
// step together on a tick while tick enable is set. The result is
// registered in the output register when the command is taken, and one
// command per cycle is sustained while the receiver keeps taking results.
// When the receiver stalls, the result is held in the output register and
// one more command is still taken into a skid stage; o_in_stall then rises
// until the receiver takes a beat.
// Configuration (invert mask, tick enable) is written through i_cfg_we /
// i_cfg_index / i_cfg_data; the user must write it only while the bank
// is idle, which the block does not enforce. Synchronous reset clears the
// pin latch, counters and configuration, and empties the output stages.
module output_pulse_timer_bank #(
    parameter int NUM_OUTPUTS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [optb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [optb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [optb_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [optb_pkg::CHANNEL_W-1:0]    i_channel,
    input  logic                              i_level,
    input  logic [optb_pkg::DUR_W-1:0]        i_pulse_ticks,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [optb_pkg::PINS_OUT_W-1:0]   o_pin_levels,
    output logic                              o_read_level
);
    import optb_pkg::*;

    logic    in_ready;
    logic    in_accept;
    t_result core_result;
    t_result out_result;

    assign o_in_stall = !in_ready;
    assign in_accept  = i_in_valid && in_ready;

    optb_core #(
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_level       (i_level),
        .i_pulse_ticks (i_pulse_ticks),
        .o_result      (core_result)
    );

    optb_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (in_ready),
        .i_data  (core_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_pin_levels = out_result.pin_levels;
    assign o_read_level = out_result.read_level;

endmodule

@@ rtl/optb_core.sv @@
// pin latch, per-pin pulse counters and the single-pass update for one beat
module optb_core #(
    parameter int NUM_OUTPUTS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [optb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [optb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_accept,
    input  logic [optb_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [optb_pkg::CHANNEL_W-1:0]    i_channel,
    input  logic                              i_level,
    input  logic [optb_pkg::DUR_W-1:0]        i_pulse_ticks,
    output optb_pkg::t_result                 o_result
);
    import optb_pkg::*;

    logic [PINS_OUT_W-1:0]  r_invert_mask;
    logic                   r_tick_enable;
    logic [NUM_OUTPUTS-1:0] r_latch;
    logic [NUM_OUTPUTS-1:0] n_latch;
    logic [NUM_OUTPUTS-1:0] rd_vec;

    logic is_tick, is_set, is_toggle, is_pulse, is_get;
    logic dur_nonzero;
    logic [COUNT_WIDTH-1:0] load_value;

    always_comb begin
        is_tick   = 1'b0;
        is_set    = 1'b0;
        is_toggle = 1'b0;
        is_pulse  = 1'b0;
        is_get    = 1'b0;
        unique case (t_opcode'(i_opcode))
            OP_TICK:   is_tick   = 1'b1;
            OP_SET:    is_set    = 1'b1;
            OP_TOGGLE: is_toggle = 1'b1;
            OP_PULSE:  is_pulse  = 1'b1;
            OP_GET:    is_get    = 1'b1;
            default:   ;
        endcase
    end

    assign dur_nonzero = |i_pulse_ticks;

    // saturate the duration into the counter width
    if (COUNT_WIDTH >= DUR_W) begin : g_load_wide
        assign load_value = COUNT_WIDTH'(i_pulse_ticks);
    end else begin : g_load_narrow
        assign load_value = (|i_pulse_ticks[DUR_W-1:COUNT_WIDTH]) ?
                            {COUNT_WIDTH{1'b1}} : i_pulse_ticks[COUNT_WIDTH-1:0];
    end

    for (genvar g = 0; g < NUM_OUTPUTS; g++) begin : g_lane
        logic                   hit;
        logic                   inv;
        logic                   cnt_zero;
        logic [COUNT_WIDTH-1:0] r_count;
        logic [COUNT_WIDTH-1:0] n_count;
        logic                   n_bit;

        assign hit      = ({{(LANE_IDX_W-CHANNEL_W){1'b0}}, i_channel} == LANE_IDX_W'(g));
        assign cnt_zero = (r_count == '0);

        if (g < PINS_OUT_W) begin : g_inv
            assign inv = r_invert_mask[g];
        end else begin : g_noinv
            assign inv = 1'b0;
        end

        always_comb begin
            n_count = r_count;
            n_bit   = r_latch[g];
            if (is_tick) begin
                if (r_tick_enable && !cnt_zero) begin
                    n_count = r_count - COUNT_WIDTH'(1);
                    // counter reaching zero ends the pulse
                    if (r_count == COUNT_WIDTH'(1)) begin
                        n_bit = ~r_latch[g];
                    end
                end
            end else if (hit) begin
                if (is_set) begin
                    n_bit = i_level ^ inv;
                end else if (is_toggle) begin
                    n_bit = ~r_latch[g];
                end else if (is_pulse && dur_nonzero) begin
                    if (cnt_zero) begin
                        n_bit = ~r_latch[g];
                    end
                    n_count = load_value;
                end
            end
        end

        assign n_latch[g] = n_bit;
        assign rd_vec[g]  = hit && is_get && (r_latch[g] ^ inv);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_count <= '0;
            end else if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch       <= '0;
            r_invert_mask <= '0;
            r_tick_enable <= 1'b0;
        end else begin
            if (i_accept) begin
                r_latch <= n_latch;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_INVERT_MASK: r_invert_mask <= i_cfg_data;
                    CFG_TICK_ENABLE: r_tick_enable <= i_cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    if (NUM_OUTPUTS >= PINS_OUT_W) begin : g_pins_wide
        assign o_result.pin_levels = n_latch[PINS_OUT_W-1:0];
    end else begin : g_pins_narrow
        assign o_result.pin_levels = {{(PINS_OUT_W-NUM_OUTPUTS){1'b0}}, n_latch};
    end
    assign o_result.read_level = |rd_vec;

endmodule

@@ rtl/optb_outbuf.sv @@
// result register with a skid stage between the core and the output channel
module optb_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  optb_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output optb_pkg::t_result o_data
);
    import optb_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    accept;
    logic    take;
    logic    out_free;

    assign o_ready  = !r_skid_valid;
    assign accept   = i_valid && o_ready;
    assign take     = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (accept) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // skid beat only exists behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid with empty output register");

    // a beat arriving while the output is held must land in the skid stage
    a_stalled_accept_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("beat accepted under stall was lost");

    // a skid beat moves forward as soon as the output is taken
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid beat not moved into output register");

endmodule
